FILE: design/scsa_pkg.sv
// ----------------------------------------------------------------------------
// scsa_pkg
// shared types, codes and class helpers for the size-class slab allocator
// ----------------------------------------------------------------------------
package scsa_pkg;

   localparam int ADDR_W   = 48;
   localparam int BYTES_W  = 32;
   localparam int TOTAL_W  = 64;
   localparam int LIMIT_W  = 19;
   localparam int BASE_W   = 47;
   localparam int STATUS_W = 3;
   localparam int CLASS_W  = 3;

   localparam int CLASS_COUNT = 5;
   localparam logic [LIMIT_W-1:0] HUGE_BYTES = LIMIT_W'(262144);

   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [CLASS_W-1:0]  class_type;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam status_type ST_OK        = 3'd0;
   localparam status_type ST_ZERO      = 3'd1;
   localparam status_type ST_OVERFLOW  = 3'd2;
   localparam status_type ST_NO_SLAB   = 3'd3;
   localparam status_type ST_FOREIGN   = 3'd4;
   localparam status_type ST_NULL      = 3'd5;
   localparam status_type ST_FULL      = 3'd6;

   localparam class_type CLS_TINY   = 3'd0;
   localparam class_type CLS_SMALL  = 3'd1;
   localparam class_type CLS_MEDIUM = 3'd2;
   localparam class_type CLS_LARGE  = 3'd3;
   localparam class_type CLS_HUGE   = 3'd4;

   localparam logic REG_OVERFLOW_LIMIT = 1'b0;
   localparam logic REG_POOL_BASE      = 1'b1;

   localparam logic [7:0] BYTE_ALL_FREE = 8'hFF;

   // log2 of the block size of a class
   function automatic logic [4:0] class_shift(input class_type c);
      logic [4:0] sh;
      case (c)
         CLS_TINY:   sh = 5'd8;
         CLS_SMALL:  sh = 5'd12;
         CLS_MEDIUM: sh = 5'd14;
         CLS_LARGE:  sh = 5'd16;
         default:    sh = 5'd18;
      endcase
      return sh;
   endfunction

   function automatic class_type classify(input logic [BYTES_W-1:0] b);
      class_type c;
      if (b <= BYTES_W'(256))            c = CLS_TINY;
      else if (b <= BYTES_W'(4 * 1024))  c = CLS_SMALL;
      else if (b <= BYTES_W'(16 * 1024)) c = CLS_MEDIUM;
      else if (b <= BYTES_W'(64 * 1024)) c = CLS_LARGE;
      else                               c = CLS_HUGE;
      return c;
   endfunction

endpackage

FILE: design/scsa_ram.sv
// ----------------------------------------------------------------------------
// scsa_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
module scsa_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/scsa_locate.sv
// ----------------------------------------------------------------------------
// scsa_locate
// finds the slab that holds a region offset and whether it is carved
// ----------------------------------------------------------------------------
module scsa_locate #(
   parameter int SLAB_BYTES = 1048576,
   parameter int MAX_SLABS  = 8,
   parameter int SW         = $clog2(MAX_SLABS + 1)
) (
   input  logic [scsa_pkg::ADDR_W-1:0] offset,
   input  logic [SW-1:0]               slabs_in_use,
   output logic [SW-1:0]               slab,
   output logic                        in_region
);

   logic [MAX_SLABS-1:0] past_start;

   // thermometer of slab boundaries, one compare per slab
   always_comb begin
      for (int k = 1; k <= MAX_SLABS; k++) begin
         past_start[k-1] = offset >=
            scsa_pkg::ADDR_W'(longint'(k) * longint'(SLAB_BYTES));
      end
   end

   assign slab      = SW'($countones(past_start));
   assign in_region = slab < slabs_in_use;

endmodule

FILE: design/size_class_slab_allocator.sv
// ----------------------------------------------------------------------------
// size_class_slab_allocator
// slab allocator with five size classes, lifo free stacks and slab bitmaps
// ----------------------------------------------------------------------------
// One request at a time: a transaction is taken only while the sequencer is
// idle, and a result waiting in the output register does not hold off the
// next request. A zero-size, overflow, null or no-slab request goes from
// decode straight to the response. A free locates and checks its block,
// pushes it and then does a read-modify-write of the slab bitmap memory; an
// allocate from a nonempty stack pops, locates the block and does the same
// bitmap read-modify-write. Both memories have a registered read port. An
// allocate that finds its class empty first carves a slab, pushing one block
// per cycle through the single write port of the stack memory.
// All five free stacks share one memory, each class in its own window; the
// bitmap bytes of all slabs sit in a second memory. Neither memory needs a
// clearing pass: only entries written by a carve or a push are ever read.
// ----------------------------------------------------------------------------
module size_class_slab_allocator #(
   parameter int SLAB_BYTES = 1048576,
   parameter int MAX_SLABS  = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_cmd,
   input  logic [scsa_pkg::BYTES_W-1:0]     req_byte_count,
   input  logic [scsa_pkg::ADDR_W-1:0]      req_block_address,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [scsa_pkg::STATUS_W-1:0]    rsp_status,
   output logic [scsa_pkg::ADDR_W-1:0]      rsp_granted_address,
   output logic [scsa_pkg::CLASS_W-1:0]     rsp_size_class,
   output logic                             rsp_slab_added,
   output logic [scsa_pkg::TOTAL_W-1:0]     rsp_bytes_taken_total,
   output logic [scsa_pkg::TOTAL_W-1:0]     rsp_bytes_returned_total,
   // configuration writes
   input  logic                             csr_wr_en,
   input  logic                             csr_index,
   input  logic [scsa_pkg::BASE_W-1:0]      csr_data
);

   // ---------------------------------------------------------------------
   // geometry
   // ---------------------------------------------------------------------
   localparam int NBLK0 = SLAB_BYTES / 256;
   localparam int NBLK1 = SLAB_BYTES / 4096;
   localparam int NBLK2 = SLAB_BYTES / 16384;
   localparam int NBLK3 = SLAB_BYTES / 65536;
   localparam int NBLK4 = SLAB_BYTES / 262144;
   localparam int CAP0  = MAX_SLABS * NBLK0;
   localparam int CAP1  = MAX_SLABS * NBLK1;
   localparam int CAP2  = MAX_SLABS * NBLK2;
   localparam int CAP3  = MAX_SLABS * NBLK3;
   localparam int CAP4  = MAX_SLABS * NBLK4;
   localparam int BASE1 = CAP0;
   localparam int BASE2 = BASE1 + CAP1;
   localparam int BASE3 = BASE2 + CAP2;
   localparam int BASE4 = BASE3 + CAP3;
   localparam int STACK_DEPTH = BASE4 + CAP4;
   localparam int SAW   = $clog2(STACK_DEPTH);
   localparam int OFFW  = $clog2(MAX_SLABS * SLAB_BYTES);
   localparam int REMW  = OFFW + 1;
   localparam int DW    = $clog2(CAP0 + 1);
   localparam int SW    = $clog2(MAX_SLABS + 1);
   localparam int SIW   = (MAX_SLABS > 1) ? $clog2(MAX_SLABS) : 1;
   localparam int IW    = $clog2(NBLK0);
   localparam int FCW   = $clog2(NBLK0 + 1);
   localparam int MAP_PER_SLAB = (NBLK0 + 7) / 8;
   localparam int BM_DEPTH = MAX_SLABS * MAP_PER_SLAB;
   localparam int BAW   = $clog2(BM_DEPTH);

   localparam int AW = scsa_pkg::ADDR_W;
   localparam int TW = scsa_pkg::TOTAL_W;

   // sequencer states
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECODE = 4'd1;
   localparam logic [3:0] S_CARVE  = 4'd2;
   localparam logic [3:0] S_POP    = 4'd3;
   localparam logic [3:0] S_POPW   = 4'd4;
   localparam logic [3:0] S_LOCATE = 4'd5;
   localparam logic [3:0] S_INDEX  = 4'd6;
   localparam logic [3:0] S_CHECK  = 4'd7;
   localparam logic [3:0] S_BMRD   = 4'd8;
   localparam logic [3:0] S_BMWR   = 4'd9;
   localparam logic [3:0] S_RESP   = 4'd10;

   function automatic logic [SAW-1:0] cls_base(input scsa_pkg::class_type c);
      logic [SAW-1:0] b;
      case (c)
         scsa_pkg::CLS_TINY:   b = '0;
         scsa_pkg::CLS_SMALL:  b = SAW'(BASE1);
         scsa_pkg::CLS_MEDIUM: b = SAW'(BASE2);
         scsa_pkg::CLS_LARGE:  b = SAW'(BASE3);
         default:              b = SAW'(BASE4);
      endcase
      return b;
   endfunction

   function automatic logic [FCW-1:0] cls_nblk(input scsa_pkg::class_type c);
      logic [FCW-1:0] n;
      case (c)
         scsa_pkg::CLS_TINY:   n = FCW'(NBLK0);
         scsa_pkg::CLS_SMALL:  n = FCW'(NBLK1);
         scsa_pkg::CLS_MEDIUM: n = FCW'(NBLK2);
         scsa_pkg::CLS_LARGE:  n = FCW'(NBLK3);
         default:              n = FCW'(NBLK4);
      endcase
      return n;
   endfunction

   function automatic logic [DW-1:0] cls_cap(input scsa_pkg::class_type c);
      logic [DW-1:0] n;
      case (c)
         scsa_pkg::CLS_TINY:   n = DW'(CAP0);
         scsa_pkg::CLS_SMALL:  n = DW'(CAP1);
         scsa_pkg::CLS_MEDIUM: n = DW'(CAP2);
         scsa_pkg::CLS_LARGE:  n = DW'(CAP3);
         default:              n = DW'(CAP4);
      endcase
      return n;
   endfunction

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   logic [3:0]                  state_ff, state_in;
   logic [scsa_pkg::LIMIT_W-1:0] overflow_ff;
   logic [scsa_pkg::BASE_W-1:0] pool_ff;

   logic [DW-1:0]               depth_ff [scsa_pkg::CLASS_COUNT];
   logic [DW-1:0]               depth_in [scsa_pkg::CLASS_COUNT];
   logic [SW-1:0]               slabs_ff, slabs_in;
   logic [TW-1:0]               taken_ff, taken_in;
   logic [TW-1:0]               returned_ff, returned_in;
   logic [scsa_pkg::CLASS_W-1:0] blk_class_ff [MAX_SLABS];
   logic [scsa_pkg::CLASS_W-1:0] blk_class_in [MAX_SLABS];
   logic [FCW-1:0]              free_cnt_ff [MAX_SLABS];
   logic [FCW-1:0]              free_cnt_in [MAX_SLABS];

   // current transaction
   logic                        cmd_ff, cmd_in;
   logic [scsa_pkg::BYTES_W-1:0] bytes_ff, bytes_in;
   logic [AW-1:0]               addr_ff, addr_in;
   scsa_pkg::status_type        status_ff, status_in;
   logic                        added_ff, added_in;
   logic [AW-1:0]               granted_ff, granted_in;
   logic [AW-1:0]               opnd_ff, opnd_in;
   logic                        base_ok_ff, base_ok_in;
   logic [SW-1:0]               slab_ff, slab_in;
   logic                        region_ff, region_in;
   logic [REMW-1:0]             rem_ff, rem_in;
   scsa_pkg::class_type         bsc_ff, bsc_in;
   logic                        found_ff, found_in;
   logic [BAW-1:0]              bm_addr_ff, bm_addr_in;
   logic [2:0]                  bit_ff, bit_in;

   // carve walk
   logic [FCW-1:0]              cnt_ff, cnt_in;
   logic [OFFW-1:0]             acc_ff, acc_in;

   // output register
   logic                        rsp_valid_ff, rsp_valid_in;
   scsa_pkg::status_type        rsp_status_ff, rsp_status_in;
   logic [AW-1:0]               rsp_granted_ff, rsp_granted_in;
   scsa_pkg::class_type         rsp_class_ff, rsp_class_in;
   logic                        rsp_added_ff, rsp_added_in;
   logic [TW-1:0]               rsp_taken_ff, rsp_taken_in;
   logic [TW-1:0]               rsp_returned_ff, rsp_returned_in;

   // ---------------------------------------------------------------------
   // memories and the slab locator
   // ---------------------------------------------------------------------
   logic                 st_we, st_re;
   logic [SAW-1:0]       st_waddr, st_raddr;
   logic [OFFW-1:0]      st_wdata, st_rdata;
   logic                 bm_we, bm_re;
   logic [BAW-1:0]       bm_waddr;
   logic [7:0]           bm_wdata, bm_rdata;
   logic [SW-1:0]        loc_slab;
   logic                 loc_region;

   scsa_ram #(.DEPTH(STACK_DEPTH), .WIDTH(OFFW)) u_stack_ram (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (st_wdata),
      .rd_en   (st_re),
      .rd_addr (st_raddr),
      .rd_data (st_rdata)
   );

   scsa_ram #(.DEPTH(BM_DEPTH), .WIDTH(8)) u_bitmap_ram (
      .clock   (clock),
      .wr_en   (bm_we),
      .wr_addr (bm_waddr),
      .wr_data (bm_wdata),
      .rd_en   (bm_re),
      .rd_addr (bm_addr_ff),
      .rd_data (bm_rdata)
   );

   scsa_locate #(.SLAB_BYTES(SLAB_BYTES), .MAX_SLABS(MAX_SLABS), .SW(SW)) u_locate (
      .offset       (opnd_ff),
      .slabs_in_use (slabs_ff),
      .slab         (loc_slab),
      .in_region    (loc_region)
   );

   // ---------------------------------------------------------------------
   // request decode helpers
   // ---------------------------------------------------------------------
   scsa_pkg::class_type         cls;
   logic [scsa_pkg::LIMIT_W-1:0] limit;
   logic                        over_limit;
   logic [DW-1:0]               dep_cur;
   logic [SIW-1:0]              slab_idx;
   logic [SIW-1:0]              new_idx;
   logic [4:0]                  bs_shift;
   logic [REMW-1:0]             span;
   logic [7:0]                  bit_mask;
   logic                        rsp_free;

   assign cls        = scsa_pkg::classify(bytes_ff);
   // limit never above the huge block size
   assign limit      = (overflow_ff > scsa_pkg::HUGE_BYTES) ? scsa_pkg::HUGE_BYTES
                                                            : overflow_ff;
   assign over_limit = bytes_ff > scsa_pkg::BYTES_W'(limit);
   assign dep_cur    = depth_ff[cls];
   assign slab_idx   = slab_ff[SIW-1:0];
   assign new_idx    = slabs_ff[SIW-1:0];
   assign bs_shift   = scsa_pkg::class_shift(bsc_in);
   // bytes covered by whole blocks of the slab's own class
   assign span       = REMW'(cls_nblk(bsc_in)) << bs_shift;
   assign bit_mask   = 8'(1) << bit_ff;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;

   assign req_ready  = (state_ff == S_IDLE);

   // ---------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      depth_in     = depth_ff;
      slabs_in     = slabs_ff;
      taken_in     = taken_ff;
      returned_in  = returned_ff;
      blk_class_in = blk_class_ff;
      free_cnt_in  = free_cnt_ff;
      cmd_in       = cmd_ff;
      bytes_in     = bytes_ff;
      addr_in      = addr_ff;
      status_in    = status_ff;
      added_in     = added_ff;
      granted_in   = granted_ff;
      opnd_in      = opnd_ff;
      base_ok_in   = base_ok_ff;
      slab_in      = slab_ff;
      region_in    = region_ff;
      rem_in       = rem_ff;
      bsc_in       = bsc_ff;
      found_in     = found_ff;
      bm_addr_in   = bm_addr_ff;
      bit_in       = bit_ff;
      cnt_in       = cnt_ff;
      acc_in       = acc_ff;

      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_status_in   = rsp_status_ff;
      rsp_granted_in  = rsp_granted_ff;
      rsp_class_in    = rsp_class_ff;
      rsp_added_in    = rsp_added_ff;
      rsp_taken_in    = rsp_taken_ff;
      rsp_returned_in = rsp_returned_ff;

      st_we    = 1'b0;
      st_waddr = cls_base(cls) + SAW'(cnt_ff);
      st_wdata = acc_ff;
      st_re    = 1'b0;
      st_raddr = cls_base(cls) + SAW'(dep_cur) - SAW'(1);
      bm_we    = 1'b0;
      bm_waddr = bm_addr_ff;
      bm_wdata = BYTE_ALL_FREE_OR(bm_rdata);
      bm_re    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in     = req_cmd;
               bytes_in   = req_byte_count;
               addr_in    = req_block_address;
               status_in  = scsa_pkg::ST_OK;
               added_in   = 1'b0;
               granted_in = '0;
               state_in   = S_DECODE;
            end
         end

         S_DECODE: begin
            if (cmd_ff == scsa_pkg::CMD_ALLOC) begin
               if (bytes_ff == '0) begin
                  status_in = scsa_pkg::ST_ZERO;
                  state_in  = S_RESP;
               end else if (over_limit) begin
                  status_in = scsa_pkg::ST_OVERFLOW;
                  state_in  = S_RESP;
               end else if (dep_cur != '0) begin
                  state_in = S_POP;
               end else if (slabs_ff >= SW'(MAX_SLABS)) begin
                  status_in = scsa_pkg::ST_NO_SLAB;
                  state_in  = S_RESP;
               end else begin
                  // carve the next slab of the region
                  cnt_in     = '0;
                  acc_in     = OFFW'(slabs_ff * SLAB_BYTES);
                  bm_addr_in = BAW'(slabs_ff * MAP_PER_SLAB);
                  state_in   = S_CARVE;
               end
            end else begin
               if (addr_ff == '0) begin
                  status_in = scsa_pkg::ST_NULL;
                  state_in  = S_RESP;
               end else if (over_limit) begin
                  // bypassed free only counts its bytes
                  returned_in = returned_ff + TW'(bytes_ff);
                  status_in   = scsa_pkg::ST_OVERFLOW;
                  state_in    = S_RESP;
               end else begin
                  opnd_in    = addr_ff - AW'(pool_ff);
                  base_ok_in = addr_ff >= AW'(pool_ff);
                  state_in   = S_LOCATE;
               end
            end
         end

         S_CARVE: begin
            // one block pushed per cycle, bitmap bytes filled alongside
            st_we    = 1'b1;
            bm_we    = cnt_ff < FCW'((32'(cls_nblk(cls)) + 7) >> 3);
            bm_waddr = bm_addr_ff;
            bm_wdata = scsa_pkg::BYTE_ALL_FREE;
            cnt_in     = cnt_ff + FCW'(1);
            acc_in     = acc_ff + (OFFW'(1) << scsa_pkg::class_shift(cls));
            bm_addr_in = bm_addr_ff + BAW'(1);
            if (cnt_ff == cls_nblk(cls) - FCW'(1)) begin
               depth_in[cls]         = DW'(cls_nblk(cls));
               blk_class_in[new_idx] = cls;
               free_cnt_in[new_idx]  = cls_nblk(cls);
               slabs_in              = slabs_ff + SW'(1);
               taken_in              = taken_ff + TW'(SLAB_BYTES);
               added_in              = 1'b1;
               state_in              = S_POP;
            end
         end

         S_POP: begin
            st_re         = 1'b1;
            depth_in[cls] = dep_cur - DW'(1);
            state_in      = S_POPW;
         end

         S_POPW: begin
            opnd_in    = AW'(st_rdata);
            base_ok_in = 1'b1;
            state_in   = S_LOCATE;
         end

         S_LOCATE: begin
            slab_in   = loc_slab;
            region_in = loc_region && base_ok_ff;
            state_in  = S_INDEX;
         end

         S_INDEX: begin
            // block index within the slab, using the slab's own block size
            bsc_in     = blk_class_ff[slab_idx];
            rem_in     = REMW'(opnd_ff[OFFW-1:0]) - REMW'(slab_ff * SLAB_BYTES);
            found_in   = REMW'(opnd_ff[OFFW-1:0]) - REMW'(slab_ff * SLAB_BYTES) < span;
            bm_addr_in = BAW'(slab_ff * MAP_PER_SLAB)
                       + BAW'(((REMW'(opnd_ff[OFFW-1:0]) - REMW'(slab_ff * SLAB_BYTES))
                                >> bs_shift) >> 3);
            bit_in     = 3'(((REMW'(opnd_ff[OFFW-1:0]) - REMW'(slab_ff * SLAB_BYTES))
                             >> bs_shift));
            state_in   = (cmd_ff == scsa_pkg::CMD_ALLOC) ? S_BMRD : S_CHECK;
         end

         S_CHECK: begin
            if (!(region_ff && found_ff)) begin
               status_in = scsa_pkg::ST_FOREIGN;
               state_in  = S_RESP;
            end else if (dep_cur >= cls_cap(cls)) begin
               status_in = scsa_pkg::ST_FULL;
               state_in  = S_RESP;
            end else begin
               // push onto the stack of the requested class
               st_we                 = 1'b1;
               st_waddr              = cls_base(cls) + SAW'(dep_cur);
               st_wdata              = opnd_ff[OFFW-1:0];
               depth_in[cls]         = dep_cur + DW'(1);
               returned_in           = returned_ff
                                     + (TW'(1) << scsa_pkg::class_shift(bsc_ff));
               free_cnt_in[slab_idx] = free_cnt_ff[slab_idx] + FCW'(1);
               state_in              = S_BMRD;
            end
         end

         S_BMRD: begin
            bm_re = 1'b1;
            if (cmd_ff == scsa_pkg::CMD_ALLOC) begin
               free_cnt_in[slab_idx] = free_cnt_ff[slab_idx] - FCW'(1);
               granted_in            = AW'(pool_ff) + AW'(opnd_ff[OFFW-1:0]);
            end
            state_in = S_BMWR;
         end

         S_BMWR: begin
            bm_we    = 1'b1;
            bm_wdata = (cmd_ff == scsa_pkg::CMD_ALLOC) ? (bm_rdata & ~bit_mask)
                                                       : (bm_rdata | bit_mask);
            state_in = S_RESP;
         end

         S_RESP: begin
            if (rsp_free) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = status_ff;
               rsp_granted_in  = granted_ff;
               rsp_added_in    = added_ff;
               rsp_taken_in    = taken_ff;
               rsp_returned_in = returned_ff;
               // class only reported once the request was classified
               if (status_ff == scsa_pkg::ST_OK || status_ff == scsa_pkg::ST_NO_SLAB ||
                   status_ff == scsa_pkg::ST_FOREIGN || status_ff == scsa_pkg::ST_FULL) begin
                  rsp_class_in = cls;
               end else begin
                  rsp_class_in = scsa_pkg::CLS_TINY;
               end
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   function automatic logic [7:0] BYTE_ALL_FREE_OR(input logic [7:0] d);
      return d | scsa_pkg::BYTE_ALL_FREE;
   endfunction

   // ---------------------------------------------------------------------
   // control state
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         overflow_ff  <= scsa_pkg::LIMIT_W'(262144);
         pool_ff      <= scsa_pkg::BASE_W'(1048576);
         slabs_ff     <= '0;
         taken_ff     <= '0;
         returned_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < scsa_pkg::CLASS_COUNT; c++) begin
            depth_ff[c] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         slabs_ff     <= slabs_in;
         taken_ff     <= taken_in;
         returned_ff  <= returned_in;
         rsp_valid_ff <= rsp_valid_in;
         depth_ff     <= depth_in;
         if (csr_wr_en) begin
            case (csr_index)
               scsa_pkg::REG_OVERFLOW_LIMIT: overflow_ff <= csr_data[scsa_pkg::LIMIT_W-1:0];
               scsa_pkg::REG_POOL_BASE:      pool_ff     <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------
   // payload registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      blk_class_ff    <= blk_class_in;
      free_cnt_ff     <= free_cnt_in;
      cmd_ff          <= cmd_in;
      bytes_ff        <= bytes_in;
      addr_ff         <= addr_in;
      status_ff       <= status_in;
      added_ff        <= added_in;
      granted_ff      <= granted_in;
      opnd_ff         <= opnd_in;
      base_ok_ff      <= base_ok_in;
      slab_ff         <= slab_in;
      region_ff       <= region_in;
      rem_ff          <= rem_in;
      bsc_ff          <= bsc_in;
      found_ff        <= found_in;
      bm_addr_ff      <= bm_addr_in;
      bit_ff          <= bit_in;
      cnt_ff          <= cnt_in;
      acc_ff          <= acc_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_granted_ff  <= rsp_granted_in;
      rsp_class_ff    <= rsp_class_in;
      rsp_added_ff    <= rsp_added_in;
      rsp_taken_ff    <= rsp_taken_in;
      rsp_returned_ff <= rsp_returned_in;
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_status               = rsp_status_ff;
   assign rsp_granted_address      = rsp_granted_ff;
   assign rsp_size_class           = rsp_class_ff;
   assign rsp_slab_added           = rsp_added_ff;
   assign rsp_bytes_taken_total    = rsp_taken_ff;
   assign rsp_bytes_returned_total = rsp_returned_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   // a carve only starts from an empty class stack
   a_carve_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECODE && state_in == S_CARVE) |-> dep_cur == '0)
      else $error("carve started with a nonempty stack");

   // never more slabs than the region holds
   a_slab_bound: assert property (@(posedge clock) disable iff (reset)
      slabs_ff <= SW'(MAX_SLABS))
      else $error("slab count beyond region");

   // tiny stack depth stays within its capacity
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff[0] <= DW'(CAP0))
      else $error("tiny stack depth beyond capacity");

   // a carve is only reported on a granted allocate
   a_added_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_added_ff) |-> rsp_status_ff == scsa_pkg::ST_OK)
      else $error("slab added on a failed request");

endmodule
